[rtl/acm_pkg.sv]
// Package for the CAN frame airtime meter.
// Field widths, register indexes, FSM states and the DLC-to-length table.
// No dependencies.
`default_nettype none

package acm_pkg;

    localparam int unsigned NOM_W   = 23;
    localparam int unsigned DAT_W   = 24;
    localparam int unsigned CFG_W   = 24;
    localparam int unsigned DLC_W   = 4;
    localparam int unsigned BITS_W  = 10;
    localparam int unsigned TIME_W  = 30;
    localparam int unsigned TOTAL_W = 32;

    localparam logic [NOM_W-1:0] NOM_RESET = NOM_W'(500000);
    localparam logic [DAT_W-1:0] DAT_RESET = DAT_W'(2000000);
    localparam logic [19:0]      US_PER_S  = 20'd1000000;

    typedef enum logic
    {
        CFG_NOMINAL = 1'b0,
        CFG_DATA    = 1'b1
    } acm_cfg_idx_t;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_LOAD,
        ST_DIV1,
        ST_DIV2,
        ST_OUT
    } acm_state_t;

    typedef struct packed
    {
        logic busy;
        logic done;
    } acm_div_stat_t;

    function automatic logic [6:0] payload_len(input logic [DLC_W-1:0] code);
        logic [6:0] len;
        unique case (code)
            4'd9:    len = 7'd12;
            4'd10:   len = 7'd16;
            4'd11:   len = 7'd20;
            4'd12:   len = 7'd24;
            4'd13:   len = 7'd32;
            4'd14:   len = 7'd48;
            4'd15:   len = 7'd64;
            default: len = {3'b000, code};
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

[rtl/acm_in_if.sv]
// Request channel of the airtime meter: one frame descriptor per request.
// Depends on acm_pkg.
`default_nettype none

interface acm_in_if import acm_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [DLC_W-1:0] length_code;
    logic             extended_id;
    logic             fd_frame;
    logic             rate_switch;

    modport source (output valid, output length_code, output extended_id,
                    output fd_frame, output rate_switch, input ready);
    modport sink   (input valid, input length_code, input extended_id,
                    input fd_frame, input rate_switch, output ready);
endinterface

`default_nettype wire

[rtl/acm_out_if.sv]
// Result channel of the airtime meter: frame time and running total.
// Depends on acm_pkg.
`default_nettype none

interface acm_out_if import acm_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [TIME_W-1:0]  frame_time;
    logic [TOTAL_W-1:0] total_time;

    modport source (output valid, output frame_time, output total_time, input ready);
    modport sink   (input valid, input frame_time, input total_time, output ready);
endinterface

`default_nettype wire

[rtl/acm_bitcount.sv]
// Bit counts of a frame: first part (classic frame or FD arbitration)
// and FD data part; the classic and FD data counts include stuff-bit estimates. Depends on acm_pkg.
`default_nettype none

module acm_bitcount import acm_pkg::*; (
    input  wire logic [DLC_W-1:0]  length_code,
    input  wire logic              extended_id,
    input  wire logic              fd_frame,
    output logic      [BITS_W-1:0] first_bits,
    output logic      [BITS_W-1:0] fd_payload_bits
);

    logic [6:0]  len;
    logic [9:0]  raw_classic;
    logic [13:0] stuffed_classic;
    logic [9:0]  classic_bits;
    logic [9:0]  raw_data;
    logic [14:0] stuffed_data;
    logic [9:0]  fd_header_bits;

    always_comb
    begin
        len             = payload_len(length_code);
        raw_classic     = (extended_id ? 10'd64 : 10'd44) + {len, 3'b000};
        stuffed_classic = 14'(raw_classic) * 14'd17;
        classic_bits    = stuffed_classic[13:4] + 10'd3;
        raw_data        = {len, 3'b000} + ((len <= 7'd16) ? 10'd28 : 10'd33);
        stuffed_data    = 15'(raw_data) * 15'd33;
        fd_header_bits  = extended_id ? 10'd36 : 10'd18;
        first_bits      = fd_frame ? fd_header_bits : classic_bits;
        fd_payload_bits = stuffed_data[14:5];
    end

endmodule

`default_nettype wire

[rtl/acm_div.sv]
// Bit-serial restoring divider: quotient = dividend / divisor, one
// quotient bit per cycle. Depends on acm_pkg.
`default_nettype none

module acm_div import acm_pkg::*; (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [TIME_W-1:0] dividend,
    input  wire logic [DAT_W-1:0]  divisor,
    output acm_div_stat_t          stat,
    output logic      [TIME_W-1:0] quotient
);

    localparam int unsigned CNT_W = $clog2(TIME_W + 1);

    logic [TIME_W-1:0] quo_reg, quo_next;
    logic [DAT_W-1:0]  rem_reg, rem_next;
    logic [DAT_W-1:0]  dvs_reg, dvs_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DAT_W:0]    trial;
    logic [DAT_W:0]    diff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    always_comb
    begin
        trial     = {rem_reg, quo_reg[TIME_W-1]};
        diff      = trial - {1'b0, dvs_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = CNT_W'(TIME_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[TIME_W-2:0], ~diff[DAT_W]};
            rem_next = diff[DAT_W] ? trial[DAT_W-1:0] : diff[DAT_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

`default_nettype wire

[rtl/can_frame_airtime_meter.sv]
// CAN frame airtime meter. Each request describes one frame; the result is
// its bus time in microseconds and the wrapping 32-bit running total. Each
// part is bits * 1e6 / rate, truncated, on a bit-serial divider. Requests are
// taken one at a time: a new request is taken only after the previous result
// is registered, which can wait on result_out.ready; a frame with zero nominal
// rate (or zero data rate with switching) skips the divider and gives zero.
// The user must write rates through cfg_* only while idle; the block itself
// does not enforce this.
// Depends on acm_pkg, acm_in_if, acm_out_if, acm_bitcount, acm_div.
`default_nettype none

module can_frame_airtime_meter import acm_pkg::*; (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic             cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data,
    acm_in_if.sink                frame_in,
    acm_out_if.source             result_out
);

    acm_state_t         state_reg, state_next;
    logic [NOM_W-1:0]   nom_reg;
    logic [DAT_W-1:0]   dat_reg;
    logic [BITS_W-1:0]  bits1_reg, bits1_next;
    logic [BITS_W-1:0]  bits2_reg, bits2_next;
    logic               fd_reg, fd_next;
    logic               brs_reg, brs_next;
    logic [TIME_W-1:0]  acc_reg, acc_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic               ovalid_reg, ovalid_next;
    logic [TIME_W-1:0]  oframe_reg, oframe_next;
    logic [BITS_W-1:0]  first_bits;
    logic [BITS_W-1:0]  fd_payload_bits;
    logic               accept;
    logic               zero_rate;
    logic               div_start;
    logic [BITS_W-1:0]  div_bits;
    logic [DAT_W-1:0]   div_rate;
    logic [TIME_W-1:0]  div_dividend;
    logic [TIME_W-1:0]  div_quo;
    acm_div_stat_t      div_stat;

    acm_bitcount u_bitcount (
        .length_code     (frame_in.length_code),
        .extended_id     (frame_in.extended_id),
        .fd_frame        (frame_in.fd_frame),
        .first_bits      (first_bits),
        .fd_payload_bits (fd_payload_bits)
    );

    assign div_dividend = TIME_W'(div_bits) * TIME_W'(US_PER_S);

    acm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_rate),
        .stat     (div_stat),
        .quotient (div_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            nom_reg    <= NOM_RESET;
            dat_reg    <= DAT_RESET;
            total_reg  <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            total_reg  <= total_next;
            ovalid_reg <= ovalid_next;
            if (cfg_we)
            begin
                unique case (acm_cfg_idx_t'(cfg_index))
                    CFG_NOMINAL: nom_reg <= cfg_data[NOM_W-1:0];
                    CFG_DATA:    dat_reg <= cfg_data[DAT_W-1:0];
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        bits1_reg  <= bits1_next;
        bits2_reg  <= bits2_next;
        fd_reg     <= fd_next;
        brs_reg    <= brs_next;
        acc_reg    <= acc_next;
        oframe_reg <= oframe_next;
    end

    assign frame_in.ready = (state_reg == ST_IDLE);
    assign accept    = frame_in.valid && frame_in.ready;
    assign zero_rate = (nom_reg == '0)
                    || (frame_in.fd_frame && frame_in.rate_switch && dat_reg == '0);

    always_comb
    begin
        state_next     = state_reg;
        bits1_next     = bits1_reg;
        bits2_next     = bits2_reg;
        fd_next        = fd_reg;
        brs_next       = brs_reg;
        acc_next       = acc_reg;
        total_next     = total_reg;
        oframe_next    = oframe_reg;
        ovalid_next    = ovalid_reg && !result_out.ready;
        div_start      = 1'b0;
        div_bits       = bits2_reg;
        div_rate       = brs_reg ? dat_reg : DAT_W'(nom_reg);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    bits1_next = first_bits;
                    bits2_next = fd_payload_bits;
                    fd_next    = frame_in.fd_frame;
                    brs_next   = frame_in.rate_switch;
                    acc_next   = '0;
                    state_next = zero_rate ? ST_OUT : ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                div_start  = 1'b1;
                div_bits   = bits1_reg;
                div_rate   = DAT_W'(nom_reg);
                state_next = ST_DIV1;
            end
            ST_DIV1:
            begin
                if (div_stat.done)
                begin
                    acc_next = div_quo;
                    if (fd_reg)
                    begin
                        div_start  = 1'b1;
                        state_next = ST_DIV2;
                    end
                    else
                    begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_DIV2:
            begin
                if (div_stat.done)
                begin
                    acc_next   = acc_reg + div_quo;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!ovalid_reg || result_out.ready)
                begin
                    oframe_next = acc_reg;
                    total_next  = total_reg + TOTAL_W'(acc_reg);
                    ovalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign result_out.valid      = ovalid_reg;
    assign result_out.frame_time = oframe_reg;
    assign result_out.total_time = total_reg;

endmodule

`default_nettype wire

[test/acm_airtime_checker.sv]
`timescale 1ns / 1ps
// Airtime checker: watches the config port and both channels, predicts the frame time
// and running total of every accepted request, and compares the results in order.
// Depends on acm_pkg, acm_in_if, acm_out_if.

module acm_airtime_checker import acm_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  acm_cfg_idx_t     cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    acm_in_if                frame_in,
    acm_out_if               result_out,
    output int               fail_count,
    output int               pending
);

    typedef struct packed
    {
        logic [TIME_W-1:0]  frame_time;
        logic [TOTAL_W-1:0] total_time;
    } airtime_t;

    localparam byte unsigned DLC_BYTES [16] =
        '{0, 1, 2, 3, 4, 5, 6, 7, 8, 12, 16, 20, 24, 32, 48, 64};

    logic [NOM_W-1:0]   nominal_rate = NOM_RESET;
    logic [DAT_W-1:0]   data_rate    = DAT_RESET;
    logic [TOTAL_W-1:0] airtime_sum  = '0;
    airtime_t           airtime_q [$];
    airtime_t           want;
    logic [TIME_W-1:0]  frame_us;
    int                 mismatches   = 0;
    int                 waiting      = 0;
    int                 result_count = 0;

    assign fail_count = mismatches;
    assign pending    = waiting;

    function automatic logic [TIME_W-1:0] frame_airtime_us(
        input logic [DLC_W-1:0] code,
        input logic             ext,
        input logic             fd,
        input logic             brs,
        input logic [NOM_W-1:0] nom,
        input logic [DAT_W-1:0] dat
    );
        longint unsigned nbytes;
        longint unsigned bits;
        longint unsigned arb;
        longint unsigned drate;
        longint unsigned us;
        nbytes = DLC_BYTES[code];
        if (nom == 0)
            return '0;
        if (!fd)
        begin
            bits = (ext ? 64 : 44) + nbytes * 8;
            bits = (bits * 17) / 16 + 3;
            us   = (bits * 1000000) / nom;
        end
        else
        begin
            arb   = ext ? 36 : 18;
            bits  = nbytes * 8 + ((nbytes <= 16) ? 28 : 33);
            bits  = (bits * 33) / 32;
            drate = brs ? longint'(dat) : longint'(nom);
            if (drate == 0)
                return '0;
            us = (arb * 1000000) / nom + (bits * 1000000) / drate;
        end
        return us[TIME_W-1:0];
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nominal_rate = NOM_RESET;
            data_rate    = DAT_RESET;
            airtime_sum  = '0;
            airtime_q.delete();
            waiting      = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_NOMINAL: nominal_rate = cfg_data[NOM_W-1:0];
                    CFG_DATA:    data_rate    = cfg_data[DAT_W-1:0];
                    default:     ;
                endcase
            end
            if (frame_in.valid && frame_in.ready)
            begin
                frame_us = frame_airtime_us(frame_in.length_code, frame_in.extended_id,
                                            frame_in.fd_frame, frame_in.rate_switch,
                                            nominal_rate, data_rate);
                airtime_sum = airtime_sum + TOTAL_W'(frame_us);
                airtime_q.push_back('{frame_time: frame_us, total_time: airtime_sum});
            end
            if (result_out.valid && result_out.ready)
            begin
                if (airtime_q.size() == 0)
                    report_mismatch($sformatf("result %0d with no request pending",
                                              result_count));
                else
                begin
                    want = airtime_q.pop_front();
                    if (result_out.frame_time !== want.frame_time)
                        report_mismatch($sformatf("result %0d frame_time %0d, want %0d",
                                                  result_count, result_out.frame_time,
                                                  want.frame_time));
                    if (result_out.total_time !== want.total_time)
                        report_mismatch($sformatf("result %0d total_time %0d, want %0d",
                                                  result_count, result_out.total_time,
                                                  want.total_time));
                end
                result_count++;
            end
            waiting = airtime_q.size();
        end
    end

endmodule

[test/tb_can_frame_airtime_meter.sv]
`timescale 1ns / 1ps
// Testbench top for can_frame_airtime_meter: clock, reset, rate settings and frame
// requests with random gaps and result back-pressure; the verdict comes from the checker.
// Depends on acm_pkg, acm_in_if, acm_out_if, acm_airtime_checker and the block.

module tb_can_frame_airtime_meter;
    import acm_pkg::*;

    localparam int LIMIT_CYCLES = 1000000;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE       = 80;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    acm_cfg_idx_t     cfg_index;
    logic [CFG_W-1:0] cfg_data;
    int               fail_count;
    int               pending;
    int               cycle_count = 0;
    logic             calm = 1'b0;
    logic             hold_req = 1'b0;

    acm_in_if  in_if ();
    acm_out_if out_if ();

    can_frame_airtime_meter dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .frame_in   (in_if),
        .result_out (out_if)
    );

    acm_airtime_checker airtime_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .frame_in   (in_if),
        .result_out (out_if),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // mostly short idles, a few long ones
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [CFG_W-1:0] pick_nominal();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return CFG_W'($urandom_range(1, 1000));
        if (r < 6)
        begin
            case ($urandom_range(0, 3))
                0:       return CFG_W'(125000);
                1:       return CFG_W'(250000);
                2:       return CFG_W'(500000);
                default: return CFG_W'(1000000);
            endcase
        end
        return CFG_W'($urandom_range(1, 8000000));
    endfunction

    function automatic logic [CFG_W-1:0] pick_data();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return CFG_W'($urandom_range(1, 1000));
        if (r < 6)
        begin
            case ($urandom_range(0, 4))
                0:       return CFG_W'(1000000);
                1:       return CFG_W'(2000000);
                2:       return CFG_W'(4000000);
                3:       return CFG_W'(5000000);
                default: return CFG_W'(8000000);
            endcase
        end
        return CFG_W'($urandom_range(1, 16000000));
    endfunction

    task automatic send_frame(input logic [DLC_W-1:0] code, input logic ext,
                              input logic fd, input logic brs);
        int gap;
        gap = idle_len();
        if (gap > 0)
        begin
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_if.valid       <= 1'b1;
        in_if.length_code <= code;
        in_if.extended_id <= ext;
        in_if.fd_frame    <= fd;
        in_if.rate_switch <= brs;
        @(posedge clk);
        while (!in_if.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic random_frames(input int count);
        for (int i = 0; i < count; i++)
            send_frame(DLC_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    task automatic drain();
        in_if.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic set_rates(input logic [CFG_W-1:0] nom_word,
                             input logic [CFG_W-1:0] dat_word);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_NOMINAL;
        cfg_data  <= nom_word;
        @(negedge clk);
        cfg_index <= CFG_DATA;
        cfg_data  <= dat_word;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin : receiver
        int stall;
        out_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                stall = idle_len();
                if (stall == 0)
                    out_if.ready <= 1'b1;
                else
                begin
                    out_if.ready <= 1'b0;
                    repeat (stall - 1) @(negedge clk);
                end
            end
        end
    end

    initial
    begin : stimulus
        logic [2:0] sel;
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = CFG_NOMINAL;
        cfg_data          = '0;
        in_if.valid       = 1'b0;
        in_if.length_code = '0;
        in_if.extended_id = 1'b0;
        in_if.fd_frame    = 1'b0;
        in_if.rate_switch = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset rates: every length code, every format combination
        for (int i = 0; i < 16; i++)
        begin
            sel = (i < 8) ? i[2:0] : ~i[2:0];
            send_frame(DLC_W'(i), sel[0], sel[1], sel[2]);
        end
        send_frame(4'd15, 1'b1, 1'b1, 1'b1);
        send_frame(4'd15, 1'b1, 1'b0, 1'b1);
        send_frame(4'd0, 1'b0, 1'b1, 1'b0);
        send_frame(4'd8, 1'b0, 1'b1, 1'b1);
        drain();

        // slowest rates (total wraps), fastest, disabled, zero data rate, junk upper bit
        set_rates(CFG_W'(1), CFG_W'(1));
        random_frames(60);
        drain();
        set_rates(CFG_W'(8000000), CFG_W'(16000000));
        random_frames(60);
        drain();
        set_rates('0, CFG_W'(2000000));
        random_frames(60);
        drain();
        set_rates(CFG_W'(1000000), '0);
        random_frames(60);
        drain();
        set_rates(CFG_W'(24'h800000 | 250000), CFG_W'(1));
        random_frames(60);
        drain();

        for (int phase = 0; phase < 9; phase++)
        begin
            set_rates(pick_nominal(), pick_data());
            if (phase == 0)
            begin
                calm     = 1'b1;
                hold_req = 1'b1;
                random_frames(8);
                calm     = 1'b0;
            end
            if (phase == 3)
                calm = 1'b1;
            random_frames(150);
            calm = 1'b0;
            drain();
        end

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[can_frame_airtime_meter.f]
rtl/acm_pkg.sv
rtl/acm_in_if.sv
rtl/acm_out_if.sv
rtl/acm_bitcount.sv
rtl/acm_div.sv
rtl/can_frame_airtime_meter.sv
test/acm_airtime_checker.sv
test/tb_can_frame_airtime_meter.sv
